// ----- rtl/core/dept_pkg.sv -----
// ----------------------------------------------------------------------------
// dept_pkg: shared widths and constants of the double-ended palindromic tree
// Sizes of the letter store, node table and child table, plus their port
// bundles and the child table address function.
// ----------------------------------------------------------------------------
package dept_pkg;

  localparam int unsigned MaxChars  = 65536;
  localparam int unsigned Alphabet  = 26;
  localparam int unsigned NodeCap   = MaxChars + 2;
  localparam int unsigned StoreCap  = 2 * MaxChars + 2;
  localparam int unsigned ChildCap  = NodeCap * Alphabet;

  localparam int unsigned NodeW     = $clog2(NodeCap);
  localparam int unsigned PosW      = $clog2(StoreCap);
  localparam int unsigned ChildAw   = $clog2(ChildCap);
  localparam int unsigned LenW      = NodeW + 1;
  localparam int unsigned LetterW   = 5;
  localparam int unsigned CountW    = 32;
  localparam int unsigned DistW     = 17;

  // Node data word: length, suffix link and link depth of one node.
  typedef struct packed {
    logic signed [LenW-1:0]  len;
    logic        [NodeW-1:0] link;
    logic        [NodeW-1:0] depth;
  } node_t;

  localparam int unsigned NodeDw = $bits(node_t);

  // Letter store port bundle.
  typedef struct packed {
    logic               we;
    logic [PosW-1:0]    waddr;
    logic [LetterW-1:0] wdata;
    logic [PosW-1:0]    raddr;
  } store_req_t;

  // Node table port bundle.
  typedef struct packed {
    logic             we;
    logic [NodeW-1:0] waddr;
    node_t            wdata;
    logic [NodeW-1:0] raddr;
  } node_req_t;

  // Child table port bundle.
  typedef struct packed {
    logic               we;
    logic [ChildAw-1:0] waddr;
    logic [NodeW-1:0]   wdata;
    logic [ChildAw-1:0] raddr;
  } child_req_t;

  // Child table address of (node, letter), multiply by a constant.
  function automatic logic [ChildAw-1:0] child_addr(logic [NodeW-1:0] node,
                                                    logic [LetterW-1:0] c);
    logic [ChildAw-1:0] base;
    base = ChildAw'(node) * ChildAw'(Alphabet);
    return base + ChildAw'(c);
  endfunction

endpackage

// ----- rtl/core/dept_ram.sv -----
// ----------------------------------------------------------------------------
// dept_ram: generic single-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dept_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/dept_store.sv -----
// ----------------------------------------------------------------------------
// dept_store: memories of the palindromic tree
// Letter store, node table and child table. The child table is swept clear
// after reset and reports ready when the sweep is done. Node 0 and node 1
// are supplied as constants so they need no memory initialization.
// ----------------------------------------------------------------------------
module dept_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dept_pkg::store_req_t         store_req_i,
  output logic [dept_pkg::LetterW-1:0] store_rdata_o,
  input  dept_pkg::node_req_t          node_req_i,
  output dept_pkg::node_t              node_rdata_o,
  input  dept_pkg::child_req_t         child_req_i,
  output logic [dept_pkg::NodeW-1:0]   child_rdata_o,
  output logic                         clear_done_o
);

  logic [dept_pkg::ChildAw-1:0] clr_addr_q, clr_addr_d;
  logic                         clr_busy_q, clr_busy_d;
  logic                         child_we;
  logic [dept_pkg::ChildAw-1:0] child_waddr;
  logic [dept_pkg::NodeW-1:0]   child_wdata;
  logic [dept_pkg::NodeDw-1:0]  node_raw;
  logic [dept_pkg::NodeW-1:0]   node_raddr_q;
  dept_pkg::node_t              node_mem_rd;

  // Sweep the child table after reset
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + dept_pkg::ChildAw'(1);
      if (clr_addr_q == dept_pkg::ChildAw'(dept_pkg::ChildCap - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      clr_busy_q   <= 1'b1;
      node_raddr_q <= '0;
    end else begin
      clr_addr_q   <= clr_addr_d;
      clr_busy_q   <= clr_busy_d;
      node_raddr_q <= node_req_i.raddr;
    end
  end

  assign clear_done_o = !clr_busy_q;
  assign child_we     = clr_busy_q | child_req_i.we;
  assign child_waddr  = clr_busy_q ? clr_addr_q : child_req_i.waddr;
  assign child_wdata  = clr_busy_q ? '0 : child_req_i.wdata;

  dept_ram #(
    .Depth(dept_pkg::StoreCap),
    .Width(dept_pkg::LetterW)
  ) u_letters (
    .clk_i  (clk_i),
    .we_i   (store_req_i.we),
    .waddr_i(store_req_i.waddr),
    .wdata_i(store_req_i.wdata),
    .raddr_i(store_req_i.raddr),
    .rdata_o(store_rdata_o)
  );

  dept_ram #(
    .Depth(dept_pkg::NodeCap),
    .Width(dept_pkg::NodeDw)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (node_req_i.we),
    .waddr_i(node_req_i.waddr),
    .wdata_i(node_req_i.wdata),
    .raddr_i(node_req_i.raddr),
    .rdata_o(node_raw)
  );

  dept_ram #(
    .Depth(dept_pkg::ChildCap),
    .Width(dept_pkg::NodeW)
  ) u_children (
    .clk_i  (clk_i),
    .we_i   (child_we),
    .waddr_i(child_waddr),
    .wdata_i(child_wdata),
    .raddr_i(child_req_i.raddr),
    .rdata_o(child_rdata_o)
  );

  // Root nodes come from constants
  always_comb begin
    node_mem_rd = dept_pkg::node_t'(node_raw);
    node_rdata_o = node_mem_rd;
    if (node_raddr_q == dept_pkg::NodeW'(0)) begin
      node_rdata_o.len   = '0;
      node_rdata_o.link  = dept_pkg::NodeW'(1);
      node_rdata_o.depth = '0;
    end else if (node_raddr_q == dept_pkg::NodeW'(1)) begin
      node_rdata_o.len   = '1;
      node_rdata_o.link  = '0;
      node_rdata_o.depth = '0;
    end
  end

endmodule

// ----- rtl/core/dept_ctrl.sv -----
// ----------------------------------------------------------------------------
// dept_ctrl: sequencer of the palindromic tree
// Places the letter, walks suffix links through the node and letter stores,
// looks up and inserts children, and keeps the counters.
// ----------------------------------------------------------------------------
module dept_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_done_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_back_i,
  input  logic [dept_pkg::LetterW-1:0] in_letter_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dept_pkg::DistW-1:0]   out_distinct_o,
  output logic [dept_pkg::CountW-1:0]  out_total_o,
  output logic                         out_dropped_o,
  output dept_pkg::store_req_t         store_req_o,
  input  logic [dept_pkg::LetterW-1:0] store_rdata_i,
  output dept_pkg::node_req_t          node_req_o,
  input  dept_pkg::node_t              node_rdata_i,
  output dept_pkg::child_req_t         child_req_o,
  input  logic [dept_pkg::NodeW-1:0]   child_rdata_i
);

  typedef enum logic [3:0] {
    StIdle,
    StWalkNode,   // node read issued, wait for node word
    StWalkChar,   // letter read issued, wait for letter
    StChild,      // child read issued
    StLinkNode,   // second walk: node read of link candidate
    StLinkChar,
    StLinkChild,  // child of link target read issued
    StDepth,      // node read issued: new suffix link or existing child
    StReply
  } state_e;

  localparam int unsigned PW = dept_pkg::PosW + 1;

  state_e                        state_q;
  logic                          back_q;
  logic [dept_pkg::LetterW-1:0]  c_q;
  logic [dept_pkg::NodeW-1:0]    v_q;
  logic [dept_pkg::NodeW-1:0]    cur_q;
  logic signed [dept_pkg::LenW-1:0] cur_len_q;
  logic [dept_pkg::NodeW-1:0]    cur_link_q;
  logic [dept_pkg::NodeW-1:0]    next_link_q;
  logic                          ok_q;
  logic [dept_pkg::NodeW-1:0]    sl_q;
  logic [dept_pkg::NodeW-1:0]    nxt_q;
  logic [dept_pkg::NodeW-1:0]    node_total_q;
  logic [dept_pkg::NodeW-1:0]    front_last_q;
  logic [dept_pkg::NodeW-1:0]    back_last_q;
  logic [dept_pkg::PosW-1:0]     left_q;
  logic [dept_pkg::PosW-1:0]     right_q;
  logic [dept_pkg::CountW-1:0]   total_q;
  logic                          dropped_q;

  logic signed [PW:0]            j_s;
  logic                          j_ok;
  logic [dept_pkg::PosW-1:0]     used;
  logic                          full;
  logic [dept_pkg::PosW-1:0]     new_left, new_right;
  logic [dept_pkg::PosW-1:0]     span;
  logic                          new_node;

  // Probe position for the node word just read
  always_comb begin
    if (back_q) begin
      j_s  = $signed({2'b00, right_q}) - $signed({{2{node_rdata_i.len[dept_pkg::LenW-1]}},
             node_rdata_i.len}) - (PW+1)'(1);
      j_ok = j_s >= $signed({2'b00, left_q});
    end else begin
      j_s  = $signed({2'b00, left_q}) + $signed({{2{node_rdata_i.len[dept_pkg::LenW-1]}},
             node_rdata_i.len}) + (PW+1)'(1);
      j_ok = j_s <= $signed({2'b00, right_q});
    end
  end

  assign used      = right_q - left_q + dept_pkg::PosW'(1);
  assign full      = (used >= dept_pkg::PosW'(dept_pkg::MaxChars)) ||
                     (node_total_q >= dept_pkg::NodeW'(dept_pkg::NodeCap));
  assign new_left  = left_q - dept_pkg::PosW'(1);
  assign new_right = right_q + dept_pkg::PosW'(1);
  assign span      = right_q - left_q + dept_pkg::PosW'(1);
  assign new_node  = (v_q == '1) && (nxt_q == node_total_q);

  assign in_ready_o     = (state_q == StIdle) && clear_done_i;
  assign out_valid_o    = (state_q == StReply);
  assign out_distinct_o = dept_pkg::DistW'(node_total_q - dept_pkg::NodeW'(2));
  assign out_total_o    = total_q;
  assign out_dropped_o  = dropped_q;

  // Memory requests
  always_comb begin
    store_req_o       = '0;
    node_req_o        = '0;
    child_req_o       = '0;
    store_req_o.raddr = j_s[dept_pkg::PosW-1:0];
    node_req_o.raddr  = v_q;
    child_req_o.raddr = dept_pkg::child_addr(cur_q, c_q);
    case (state_q)
      StIdle: begin
        store_req_o.we    = in_valid_i && in_ready_o && !full &&
                            (in_letter_i < dept_pkg::LetterW'(dept_pkg::Alphabet));
        store_req_o.waddr = in_back_i ? new_right : new_left;
        store_req_o.wdata = in_letter_i;
        node_req_o.raddr  = in_back_i ? back_last_q : front_last_q;
      end
      StWalkNode, StLinkNode: begin
        node_req_o.raddr = node_rdata_i.link;
      end
      StWalkChar: begin
        if (ok_q && store_rdata_i == c_q) begin
          child_req_o.raddr = dept_pkg::child_addr(v_q, c_q);
        end else begin
          node_req_o.raddr = next_link_q;
        end
      end
      StLinkChar: begin
        if (ok_q && store_rdata_i == c_q) begin
          child_req_o.raddr = dept_pkg::child_addr(v_q, c_q);
        end else begin
          node_req_o.raddr = next_link_q;
        end
      end
      StChild: begin
        // Existing child: fetch its node word; otherwise start the link walk
        if (child_rdata_i == '0 ||
            child_rdata_i >= dept_pkg::NodeW'(dept_pkg::NodeCap)) begin
          node_req_o.raddr = cur_link_q;
        end else begin
          node_req_o.raddr = child_rdata_i;
        end
      end
      StLinkChild: begin
        node_req_o.raddr = (child_rdata_i >= dept_pkg::NodeW'(dept_pkg::NodeCap)) ?
                           '0 : child_rdata_i;
      end
      StDepth: begin
        if (new_node) begin
          node_req_o.we          = 1'b1;
          node_req_o.waddr       = node_total_q;
          node_req_o.wdata.len   = cur_len_q + dept_pkg::LenW'(2);
          node_req_o.wdata.link  = sl_q;
          node_req_o.wdata.depth = node_rdata_i.depth + dept_pkg::NodeW'(1);
          child_req_o.we         = 1'b1;
          child_req_o.waddr      = dept_pkg::child_addr(cur_q, c_q);
          child_req_o.wdata      = node_total_q;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      node_total_q <= dept_pkg::NodeW'(2);
      front_last_q <= '0;
      back_last_q  <= '0;
      left_q       <= dept_pkg::PosW'(dept_pkg::MaxChars + 1);
      right_q      <= dept_pkg::PosW'(dept_pkg::MaxChars);
      total_q      <= '0;
      dropped_q    <= 1'b0;
      back_q       <= 1'b0;
      c_q          <= '0;
      v_q          <= '0;
      cur_q        <= '0;
      cur_len_q    <= '0;
      cur_link_q   <= '0;
      next_link_q  <= '0;
      ok_q         <= 1'b0;
      sl_q         <= '0;
      nxt_q        <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            back_q <= in_back_i;
            c_q    <= in_letter_i;
            v_q    <= in_back_i ? back_last_q : front_last_q;
            if (full || in_letter_i >= dept_pkg::LetterW'(dept_pkg::Alphabet)) begin
              dropped_q <= 1'b1;
              state_q   <= StReply;
            end else begin
              dropped_q <= 1'b0;
              if (in_back_i) begin
                right_q <= new_right;
              end else begin
                left_q <= new_left;
              end
              state_q <= StWalkNode;
            end
          end
        end
        StWalkNode, StLinkNode: begin
          // Probe the letter opposite the palindrome
          ok_q        <= j_ok && (j_s >= 0) &&
                         (j_s < $signed((PW+1)'(dept_pkg::StoreCap)));
          next_link_q <= node_rdata_i.link;
          if (state_q == StWalkNode) begin
            cur_len_q  <= node_rdata_i.len;
            cur_link_q <= node_rdata_i.link;
          end
          state_q <= (state_q == StWalkNode) ? StWalkChar : StLinkChar;
        end
        StWalkChar: begin
          if (ok_q && store_rdata_i == c_q) begin
            cur_q   <= v_q;
            state_q <= StChild;
          end else begin
            v_q     <= next_link_q;
            state_q <= StWalkNode;
          end
        end
        StChild: begin
          if (child_rdata_i == '0 || child_rdata_i >= dept_pkg::NodeW'(dept_pkg::NodeCap)) begin
            v_q     <= cur_link_q;
            state_q <= StLinkNode;
          end else begin
            nxt_q   <= child_rdata_i;
            v_q     <= child_rdata_i;
            state_q <= StDepth;
          end
        end
        StLinkChar: begin
          if (ok_q && store_rdata_i == c_q) begin
            state_q <= StLinkChild;
          end else begin
            v_q     <= next_link_q;
            state_q <= StLinkNode;
          end
        end
        StLinkChild: begin
          sl_q    <= (child_rdata_i >= dept_pkg::NodeW'(dept_pkg::NodeCap)) ?
                     '0 : child_rdata_i;
          nxt_q   <= node_total_q;
          state_q <= StDepth;
          v_q     <= '1;  // marks a newly created node
        end
        StDepth: begin
          // New node: count it; the node word and child entry are written now
          if (new_node) begin
            node_total_q <= node_total_q + dept_pkg::NodeW'(1);
          end
          state_q <= StReply;
        end
        StReply: begin
          if (out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      // Commit last nodes and total once the new node is known
      if (state_q == StDepth) begin
        if (back_q) begin
          back_last_q <= nxt_q;
        end else begin
          front_last_q <= nxt_q;
        end
        if (new_node) begin
          total_q <= total_q + dept_pkg::CountW'(node_rdata_i.depth + dept_pkg::NodeW'(1));
          if ($signed({1'b0, span}) == $signed(cur_len_q + dept_pkg::LenW'(2))) begin
            if (back_q) front_last_q <= nxt_q;
            else        back_last_q  <= nxt_q;
          end
        end else begin
          total_q <= total_q + dept_pkg::CountW'(node_rdata_i.depth);
          if ($signed({1'b0, span}) == $signed(node_rdata_i.len)) begin
            if (back_q) front_last_q <= nxt_q;
            else        back_last_q  <= nxt_q;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/double_ended_palindrome_tree.sv -----
// Flow: one item at a time; the next beat is taken the cycle after the result beat, and a
//   dropped letter skips the suffix-link walks and goes straight to the result beat.
// Reset: asynchronous, active low; afterward the child table is swept clear,
//   one entry a cycle, with s_tready low meanwhile.
// ----------------------------------------------------------------------------
// double_ended_palindrome_tree: eertree over a string growing at both ends
// Each beat adds a letter at the front or back, or is dropped, and returns
// the distinct and total palindrome counts.
// ----------------------------------------------------------------------------
module double_ended_palindrome_tree (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
  input  logic        s_tuser,   // at_back
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [16:0] distinct_count, [48:17] total_count, [55:49] zero
  output logic        m_tuser    // dropped
);

  dept_pkg::store_req_t         store_req;
  logic [dept_pkg::LetterW-1:0] store_rdata;
  dept_pkg::node_req_t          node_req;
  dept_pkg::node_t              node_rdata;
  dept_pkg::child_req_t         child_req;
  logic [dept_pkg::NodeW-1:0]   child_rdata;
  logic                         clear_done;
  logic [dept_pkg::DistW-1:0]   distinct;
  logic [dept_pkg::CountW-1:0]  total;

  dept_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .store_req_i  (store_req),
    .store_rdata_o(store_rdata),
    .node_req_i   (node_req),
    .node_rdata_o (node_rdata),
    .child_req_i  (child_req),
    .child_rdata_o(child_rdata),
    .clear_done_o (clear_done)
  );

  dept_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_done_i  (clear_done),
    .in_valid_i    (s_tvalid),
    .in_ready_o    (s_tready),
    .in_back_i     (s_tuser),
    .in_letter_i   (s_tdata[4:0]),
    .out_valid_o   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_distinct_o(distinct),
    .out_total_o   (total),
    .out_dropped_o (m_tuser),
    .store_req_o   (store_req),
    .store_rdata_i (store_rdata),
    .node_req_o    (node_req),
    .node_rdata_i  (node_rdata),
    .child_req_o   (child_req),
    .child_rdata_i (child_rdata)
  );

  assign m_tdata = {7'b0, total, distinct};

endmodule

// ----- dv/double_ended_palindrome_tree_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_palindrome_tree_tb: self-checking bench for the two-ended eertree
// Drives letters onto both ends of the string, predicts the distinct and total
// palindrome counts with a behavioral eertree and compares every output beat.
// ----------------------------------------------------------------------------
module double_ended_palindrome_tree_tb;

  localparam int unsigned WatchdogLimit = 8000000;
  localparam int unsigned TrieMax       = 4096;
  localparam int unsigned NumRandom     = 700;

  typedef struct packed {
    logic [dept_pkg::DistW-1:0]  distinct;
    logic [dept_pkg::CountW-1:0] total;
    logic                        dropped;
  } tally_t;

  typedef struct {
    logic       back;
    logic [4:0] letter;
    logic       known;
    tally_t     tally;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;

  double_ended_palindrome_tree u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Behavioral eertree, small capacity is enough for this run length
  int         text[int];
  int         plen[TrieMax];
  int         plink[TrieMax];
  int         pdepth[TrieMax];
  int         kids[int];
  int         pal_nodes;
  int         head_node;
  int         tail_node;
  int         lpos;
  int         rpos;
  logic [31:0] pal_total;

  tally_t     pending_tally[$];
  int         mismatches = 0;
  int         table_errs = 0;
  int         idle_cycles = 0;
  bit         no_stall;
  bit         hold_sink;
  bit         hold_done;
  bit         stim_done;

  function automatic int find_wrap(int v, bit back, int c);
    int j;
    bit ok;
    forever begin
      if (back) begin
        j  = rpos - plen[v] - 1;
        ok = (j >= lpos);
      end else begin
        j  = lpos + plen[v] + 1;
        ok = (j <= rpos);
      end
      if (ok && text.exists(j) && text[j] == c) return v;
      v = plink[v];
    end
  endfunction

  function automatic tally_t grow_string(bit back, logic [4:0] letter);
    tally_t t;
    int     c;
    int     cur;
    int     nxt;
    int     lk;
    int     sl;
    c = int'(letter);
    t.dropped = 1'b0;
    if (c >= dept_pkg::Alphabet || (rpos - lpos + 1) >= dept_pkg::MaxChars) begin
      t.dropped = 1'b1;
    end else begin
      if (back) begin
        rpos++;
        text[rpos] = c;
      end else begin
        lpos--;
        text[lpos] = c;
      end
      cur = find_wrap(back ? tail_node : head_node, back, c);
      nxt = kids.exists(cur * dept_pkg::Alphabet + c) ? kids[cur * dept_pkg::Alphabet + c] : 0;
      if (nxt == 0) begin
        lk = find_wrap(plink[cur], back, c);
        sl = kids.exists(lk * dept_pkg::Alphabet + c) ? kids[lk * dept_pkg::Alphabet + c] : 0;
        nxt = pal_nodes++;
        plen[nxt]   = plen[cur] + 2;
        plink[nxt]  = sl;
        pdepth[nxt] = pdepth[sl] + 1;
        kids[cur * dept_pkg::Alphabet + c] = nxt;
      end
      if (back) tail_node = nxt;
      else head_node = nxt;
      // A palindrome spanning the whole string is the last node of both ends
      if (plen[nxt] == rpos - lpos + 1) begin
        head_node = nxt;
        tail_node = nxt;
      end
      pal_total += 32'(pdepth[nxt]);
    end
    t.distinct = dept_pkg::DistW'(pal_nodes - 2);
    t.total    = pal_total;
    return t;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reset and prediction state
  initial begin
    rst_ni    = 1'b0;
    plen[0]   = 0;
    plen[1]   = -1;
    plink[0]  = 1;
    plink[1]  = 0;
    pdepth[0] = 0;
    pdepth[1] = 0;
    pal_nodes = 2;
    head_node = 0;
    tail_node = 0;
    lpos      = dept_pkg::MaxChars + 1;
    rpos      = dept_pkg::MaxChars;
    pal_total = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Source: directed table, then random letters
  task automatic send_beat(bit back, logic [4:0] letter, bit known, tally_t want);
    tally_t t;
    while (!no_stall && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, letter};
    s_tuser  <= back;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    t = grow_string(back, letter);
    pending_tally.push_back(known ? want : t);
    if (known && t != want) begin
      table_errs++;
      if (table_errs <= 10)
        $display("predictor disagrees with table: table %h model %h", want, t);
    end
  endtask

  initial begin
    row_t   rows[$];
    bit     back;
    logic [4:0] letter;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    no_stall  = 1'b0;
    hold_sink = 1'b0;
    stim_done = 1'b0;
    // Directed rows: out-of-range letters on an empty string, short palindromes, one more drop
    rows.push_back('{1'b1, 5'd31, 1'b1, '{17'd0, 32'd0, 1'b1}});
    rows.push_back('{1'b0, 5'd26, 1'b1, '{17'd0, 32'd0, 1'b1}});
    rows.push_back('{1'b1, 5'd0,  1'b1, '{17'd1, 32'd1, 1'b0}});
    rows.push_back('{1'b0, 5'd0,  1'b1, '{17'd2, 32'd3, 1'b0}});
    rows.push_back('{1'b1, 5'd25, 1'b1, '{17'd3, 32'd4, 1'b0}});
    rows.push_back('{1'b0, 5'd25, 1'b1, '{17'd4, 32'd6, 1'b0}});
    rows.push_back('{1'b0, 5'd30, 1'b1, '{17'd4, 32'd6, 1'b1}});
    rows.push_back('{1'b1, 5'd0,  1'b0, '0});
    rows.push_back('{1'b0, 5'd0,  1'b0, '0});
    rows.push_back('{1'b1, 5'd1,  1'b0, '0});
    rows.push_back('{1'b0, 5'd1,  1'b0, '0});
    rows.push_back('{1'b1, 5'd16, 1'b0, '0});
    rows.push_back('{1'b0, 5'd15, 1'b0, '0});
    rows.push_back('{1'b1, 5'd15, 1'b0, '0});
    rows.push_back('{1'b0, 5'd16, 1'b0, '0});
    @(posedge clk_i iff rst_ni);
    foreach (rows[i]) send_beat(rows[i].back, rows[i].letter, rows[i].known, rows[i].tally);

    // Pause the source until the block drains
    s_tvalid <= 1'b0;
    while (pending_tally.size() != 0) @(posedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      no_stall  = (n >= 200 && n < 300);
      hold_sink = (n >= 400 && n < 420);
      back = 1'($urandom_range(1));
      // Small alphabets build deep palindromes; a few letters fall outside
      case ($urandom_range(9))
        0:       letter = 5'($urandom_range(31));
        1, 2, 3: letter = 5'($urandom_range(1));
        4, 5:    letter = 5'($urandom_range(2));
        default: letter = 5'($urandom_range(25));
      endcase
      send_beat(back, letter, 1'b0, '0);
    end
    s_tvalid  <= 1'b0;
    no_stall  = 1'b0;
    stim_done = 1'b1;
  end

  // Sink: random stalls, one long hold-off while the source keeps offering
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_sink && !hold_done) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_tready <= no_stall || ($urandom_range(99) >= 32);
    end
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin
    tally_t got;
    tally_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tdata[16:0], m_tdata[48:17], m_tuser};
      if (pending_tally.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_tally.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: distinct exp %0d got %0d, total exp %0d got %0d, ",
                      "dropped exp %0b got %0b"},
                     want.distinct, got.distinct, want.total, got.total,
                     want.dropped, got.dropped);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat; covers the clearing sweep
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    fork
      begin
        wait (stim_done);
        while (pending_tally.size() != 0) @(posedge clk_i);
        repeat (50) @(posedge clk_i);
        if (mismatches == 0 && table_errs == 0 && pending_tally.size() == 0) begin
          $display("double_ended_palindrome_tree verification clean");
        end else begin
          $display("double_ended_palindrome_tree verification failed");
        end
      end
      begin
        wait (idle_cycles >= WatchdogLimit);
        $display("double_ended_palindrome_tree verification failed");
      end
    join_any
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dept_pkg.sv
rtl/core/dept_ram.sv
rtl/core/dept_store.sv
rtl/core/dept_ctrl.sv
rtl/core/double_ended_palindrome_tree.sv
dv/double_ended_palindrome_tree_tb.sv
